FILE: hdl/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Shared types and constants of the count entropy threshold detector.
// ----------------------------------------------------------------------------
package cet_pkg;

    localparam int COUNT_W     = 32;
    localparam int TOTAL_W     = 40;
    localparam int SUM_W       = 64;
    localparam int OUT_W       = 21;
    localparam int ENT_W       = 17;
    localparam int EXP_W       = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [OUT_W-1:0] THR_RESET = 21'd196608;

    // one queued count, classified on entry
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               nz;
    } item_t;

endpackage

FILE: hdl/cet_front.sv
// ----------------------------------------------------------------------------
// cet_front
// Accepts counts, flags zero counts and queues items for the back end.
// ----------------------------------------------------------------------------
module cet_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [cet_pkg::COUNT_W-1:0]  pkt_count,
    input  logic                         last_entry,
    output cet_pkg::item_t               head,
    output logic                         q_empty,
    input  logic                         q_pop
);
    import cet_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   rptr_reg;
    logic [PTR_W:0]     fill_reg;
    logic               wr_en;
    logic               rd_en;
    item_t              in_item;

    assign full    = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (fill_reg == '0);
    assign wr_en   = push && !full;
    assign rd_en   = q_pop && !q_empty;
    assign head    = mem_reg[rptr_reg];

    always_comb
    begin
        in_item.count = pkt_count;
        in_item.last  = last_entry;
        in_item.nz    = (pkt_count != '0);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/cet_log.sv
// ----------------------------------------------------------------------------
// cet_log
// Fixed-point log2 by repeated squaring, one fraction bit per cycle.
// ----------------------------------------------------------------------------
module cet_log #(
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [cet_pkg::TOTAL_W-1:0]                x,
    output logic                                       done,
    output logic [cet_pkg::EXP_W+LOG_FRAC_BITS-1:0]    result
);
    import cet_pkg::*;

    localparam int CNT_W = $clog2(LOG_FRAC_BITS + 1);

    logic [EXP_W-1:0]          e_reg;
    logic [31:0]               m_reg;
    logic [LOG_FRAC_BITS-1:0]  frac_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [EXP_W-1:0]          msb;
    logic [TOTAL_W+30:0]       norm;
    logic [63:0]               sq;
    logic [32:0]               sq_sh;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < TOTAL_W; i++)
        begin
            if (x[i])
            begin
                msb = EXP_W'(i);
            end
        end
    end

    // place the leading one at bit 31
    assign norm  = {x, 31'b0} >> msb;
    assign sq    = 64'(m_reg) * 64'(m_reg);
    assign sq_sh = sq[63:31];

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            e_reg    <= msb;
            m_reg    <= norm[31:0];
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq_sh[32]};
            m_reg    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LOG_FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/cet_div.sv
// ----------------------------------------------------------------------------
// cet_div
// Restoring divider of the weighted sum by the total, one bit per cycle.
// ----------------------------------------------------------------------------
module cet_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cet_pkg::SUM_W-1:0]     dividend,
    input  logic [cet_pkg::TOTAL_W-1:0]   divisor,
    output logic                          done,
    output logic [cet_pkg::SUM_W-1:0]     quotient
);
    import cet_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [TOTAL_W-1:0]  rem_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [TOTAL_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [TOTAL_W:0]    trial;
    logic [TOTAL_W:0]    diff;
    logic                ge;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/cet_back.sv
// ----------------------------------------------------------------------------
// cet_back
// Accumulates the window, then computes entropy and holds the result item.
// ----------------------------------------------------------------------------
module cet_back #(
    parameter int MAX_ENTRIES   = 65536,
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cet_pkg::item_t                head,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [cet_pkg::OUT_W-1:0]     threshold,
    output logic                          empty,
    input  logic                          pop,
    output logic [cet_pkg::OUT_W-1:0]     entropy_value,
    output logic                          attack_flag,
    output logic [cet_pkg::ENT_W-1:0]     entries_used,
    output logic                          overflow_flag
);
    import cet_pkg::*;

    localparam int LOG_W  = EXP_W + LOG_FRAC_BITS;
    localparam int PROD_W = COUNT_W + LOG_W;
    localparam int HS_W   = LOG_W + 16;
    localparam int SH_R   = (LOG_FRAC_BITS >= 16) ? LOG_FRAC_BITS - 16 : 0;
    localparam int SH_L   = (LOG_FRAC_BITS < 16) ? 16 - LOG_FRAC_BITS : 0;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOG  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    item_t               cur_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [ENT_W-1:0]    ent_reg;
    logic                ovf_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [LOG_W-1:0]    ln_reg;
    logic [SUM_W-1:0]    q_reg;
    logic                res_valid_reg;
    logic [OUT_W-1:0]    h_out_reg;
    logic                atk_reg;
    logic [ENT_W-1:0]    ent_out_reg;
    logic                ovf_out_reg;

    logic                log_start;
    logic [TOTAL_W-1:0]  log_x;
    logic                log_done;
    logic [LOG_W-1:0]    log_res;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_q;

    logic                room;
    logic [TOTAL_W:0]    total_sum;
    logic [SUM_W:0]      wsum;
    logic [LOG_W-1:0]    hf;
    logic [HS_W-1:0]     hs;
    logic [OUT_W-1:0]    h;

    assign room      = (ent_reg < ENT_W'(MAX_ENTRIES));
    assign total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(cur_reg.count);
    assign wsum      = {1'b0, sum_reg} + (SUM_W+1)'(prod_reg);

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign log_start = (q_pop && head.nz && room) ||
                       ((state_reg == ST_FIN) && (total_reg != '0));
    assign log_x     = (state_reg == ST_FIN) ? total_reg : TOTAL_W'(head.count);
    assign div_start = (state_reg == ST_FIN) && (total_reg != '0);

    always_comb
    begin
        hf = (SUM_W'(ln_reg) > q_reg) ? (ln_reg - q_reg[LOG_W-1:0]) : '0;
        hs = (HS_W'(hf) << SH_L) >> SH_R;
        h  = (hs > HS_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : hs[OUT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.nz && room)
                    begin
                        state_next = ST_LOG;
                    end
                    else if (head.last)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_LOG:
            begin
                if (log_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = cur_reg.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                state_next = (total_reg == '0) ? ST_OUT : ST_WAIT;
            end
            ST_WAIT:
            begin
                // the log finishes well before the divider
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    cet_log #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    cet_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= head;
        end
        if ((state_reg == ST_LOG) && log_done)
        begin
            prod_reg <= PROD_W'(cur_reg.count) * PROD_W'(log_res);
        end
        if ((state_reg == ST_FIN) && (total_reg == '0))
        begin
            ln_reg <= '0;
            q_reg  <= '0;
        end
        if ((state_reg == ST_WAIT) && log_done)
        begin
            ln_reg <= log_res;
        end
        if ((state_reg == ST_WAIT) && div_done)
        begin
            q_reg <= div_q;
        end
        if ((state_reg == ST_OUT) && !res_valid_reg)
        begin
            h_out_reg   <= h;
            atk_reg     <= (h < threshold);
            ent_out_reg <= ent_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            sum_reg       <= '0;
            ent_reg       <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    // drop a nonzero count once the window is full
                    if (q_pop && head.nz && !room)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_ACC:
                begin
                    ent_reg <= ent_reg + 1'b1;
                    if (total_sum[TOTAL_W])
                    begin
                        total_reg <= {TOTAL_W{1'b1}};
                        ovf_reg   <= 1'b1;
                    end
                    else
                    begin
                        total_reg <= total_sum[TOTAL_W-1:0];
                    end
                    if (wsum[SUM_W])
                    begin
                        sum_reg <= {SUM_W{1'b1}};
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_reg <= wsum[SUM_W-1:0];
                    end
                end
                ST_OUT:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        total_reg     <= '0;
                        sum_reg       <= '0;
                        ent_reg       <= '0;
                        ovf_reg       <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign empty         = !res_valid_reg;
    assign entropy_value = h_out_reg;
    assign attack_flag   = atk_reg;
    assign entries_used  = ent_out_reg;
    assign overflow_flag = ovf_out_reg;

    a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ent_reg <= ENT_W'(MAX_ENTRIES))
        else $error("entry counter beyond limit");

    a_log_nz: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOG |-> cur_reg.nz)
        else $error("log started on zero count");

    a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && total_reg == '0) |=> state_reg == ST_OUT)
        else $error("zero total did not go to output");

    a_log_owner: assert property (@(posedge clk) disable iff (!rst_n)
        log_done |-> (state_reg == ST_LOG || state_reg == ST_WAIT))
        else $error("log result with no consumer");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped while busy");

endmodule

FILE: hdl/count_entropy_threshold_detector_core.sv
// ----------------------------------------------------------------------------
// count_entropy_threshold_detector_core
// Shannon entropy of one window of per-address counts with a threshold flag.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      pkt_count, last_entry
//  result    pop / empty      entropy_value, attack_flag, entries_used,
//                             overflow_flag
//  config    cfg_valid/ready  cfg_data (detection threshold)
//
//  A four-entry input queue takes one count per cycle until full.
//  The back end passes each nonzero count through the serial log2 unit,
//  lets a zero count skip it, and pops a new count only once idle again.
//  A window is closed by the 64-step divider beside a log2 of the total;
//  a zero total skips both and goes straight to the result slot.
//  Reset clears the queue, the window state and the result slot; the
//  threshold returns to 3.0. A waiting result stalls only the window end.
// ----------------------------------------------------------------------------
module count_entropy_threshold_detector_core #(
    parameter int MAX_ENTRIES   = 65536,
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [cet_pkg::COUNT_W-1:0]   pkt_count,
    input  logic                          last_entry,
    output logic                          empty,
    input  logic                          pop,
    output logic [cet_pkg::OUT_W-1:0]     entropy_value,
    output logic                          attack_flag,
    output logic [cet_pkg::ENT_W-1:0]     entries_used,
    output logic                          overflow_flag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cet_pkg::OUT_W-1:0]     cfg_data
);
    import cet_pkg::*;

    logic [OUT_W-1:0] thr_reg;
    item_t            head;
    logic             q_empty;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    cet_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pkt_count    (pkt_count),
        .last_entry   (last_entry),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (q_pop)
    );

    cet_back #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .threshold     (thr_reg),
        .empty         (empty),
        .pop           (pop),
        .entropy_value (entropy_value),
        .attack_flag   (attack_flag),
        .entries_used  (entries_used),
        .overflow_flag (overflow_flag)
    );

endmodule
